// ===== sv/alir_pkg.sv =====
// shared types and constants for the array list insert/remove unit
package alir_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [KIND_W-1:0]        kind_t;

    // request kinds
    localparam kind_t KIND_APPEND     = 3'd0;
    localparam kind_t KIND_POP        = 3'd1;
    localparam kind_t KIND_REMOVE_VAL = 3'd2;
    localparam kind_t KIND_REMOVE_POS = 3'd3;
    localparam kind_t KIND_INSERT_POS = 3'd4;

endpackage

// ===== sv/alir_ram.sv =====
// entry store: one write port, one read port with registered read data
module alir_ram #(
    parameter int DEPTH = alir_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  alir_pkg::data_t     wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output alir_pkg::data_t     rd_data
);
    import alir_pkg::*;

    data_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/array_list_insert_remove_unit.sv =====
// array list insert/remove unit: request sequencer around the entry store
//
// An ordered list of signed 32-bit words kept contiguously in a single-port-pair
// memory of DEPTH entries, plus a count of held entries.
// Request channel (req_valid/req_ready): kind, value, position. Kinds are
// append, pop last, remove first match of value, remove at position, insert
// at position. Response channel (res_valid/res_ready): ok, removed_value
// (word taken out by pop or remove at position, else zero), count after the
// request. Exactly one response per request, in order.
// One request is worked on at a time; req_ready is high only while the
// sequencer is idle, so the next request is taken once the response is
// loaded. Each moved entry costs one memory read and one write-back, each
// searched entry a read and a compare.
// The response sits in an output register, so a new request is accepted
// while a response waits; if the receiver stalls, the next request finishes
// its memory work and then holds until the register frees up.
// Reset clears the count and the control state; memory contents are left as
// they are, since only entries below the count are ever read.
module array_list_insert_remove_unit #(
    parameter int DEPTH = alir_pkg::DEPTH_DEF,
    parameter int PW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                req_valid,
    output logic                req_ready,
    input  alir_pkg::kind_t     kind,
    input  alir_pkg::data_t     value,
    input  logic [PW-1:0]       position,
    // response channel
    output logic                res_valid,
    input  logic                res_ready,
    output logic                ok,
    output alir_pkg::data_t     removed_value,
    output logic [CW-1:0]       count
);
    import alir_pkg::*;

    localparam int AW = (PW < 1) ? 1 : PW;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    // one-hot sequencer states
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,  // waiting for a request
        S_DISP = 10'b00_0000_0010,  // check request, start first access
        S_TAKE = 10'b00_0000_0100,  // capture word being removed
        S_SRD  = 10'b00_0000_1000,  // search: read entry at idx
        S_SCMP = 10'b00_0001_0000,  // search: compare read word
        S_DNRD = 10'b00_0010_0000,  // shift down: read idx+1
        S_DNWR = 10'b00_0100_0000,  // shift down: write idx
        S_UPRD = 10'b00_1000_0000,  // shift up: read idx-1
        S_UPWR = 10'b01_0000_0000,  // shift up: write idx
        S_FIN  = 10'b10_0000_0000   // hand result to output register
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    kind_t          kind_reg, kind_next;
    data_t          value_reg, value_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic           ok_reg, ok_next;
    data_t          rem_reg, rem_next;

    // output register
    logic           res_valid_reg, res_valid_next;
    logic           res_ok_reg, res_ok_next;
    data_t          res_rem_reg, res_rem_next;
    logic [CW-1:0]  res_count_reg, res_count_next;

    // memory access
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    data_t          wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    data_t          rd_data;

    logic [CW-1:0]  idx_inc;
    logic [CW-1:0]  idx_dec;
    logic [CW-1:0]  count_dec;

    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign count_dec = count_reg - CW'(1);

    alir_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready     = (state_reg == S_IDLE);
    assign res_valid     = res_valid_reg;
    assign ok            = res_ok_reg;
    assign removed_value = res_rem_reg;
    assign count         = res_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        ok_next        = ok_reg;
        rem_next       = rem_reg;
        res_valid_next = res_valid_reg;
        res_ok_next    = res_ok_reg;
        res_rem_next   = res_rem_reg;
        res_count_next = res_count_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = kind;
                    value_next = value;
                    pos_next   = CW'(position);
                    ok_next    = 1'b0;
                    rem_next   = '0;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                state_next = S_FIN;
                case (kind_reg)
                    KIND_APPEND:
                    begin
                        if (count_reg < FULL)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = value_reg;
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    KIND_POP:
                    begin
                        // read last entry; shift-down pass then only drops the count
                        if (count_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = count_dec[AW-1:0];
                            idx_next   = count_dec;
                            state_next = S_TAKE;
                        end
                    end
                    KIND_REMOVE_VAL:
                    begin
                        idx_next   = '0;
                        state_next = S_SRD;
                    end
                    KIND_REMOVE_POS:
                    begin
                        if (pos_reg < count_reg)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pos_reg[AW-1:0];
                            idx_next   = pos_reg;
                            state_next = S_TAKE;
                        end
                    end
                    KIND_INSERT_POS:
                    begin
                        if (count_reg < FULL && pos_reg <= count_reg)
                        begin
                            idx_next   = count_reg;
                            state_next = S_UPRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_TAKE:
            begin
                rem_next   = rd_data;
                ok_next    = 1'b1;
                state_next = S_DNRD;
            end

            S_SRD:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_SCMP;
                end
                else
                begin
                    // not found
                    state_next = S_FIN;
                end
            end

            S_SCMP:
            begin
                if (rd_data == value_reg)
                begin
                    ok_next    = 1'b1;
                    state_next = S_DNRD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SRD;
                end
            end

            S_DNRD:
            begin
                if (idx_inc < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[AW-1:0];
                    state_next = S_DNWR;
                end
                else
                begin
                    count_next = count_dec;
                    state_next = S_FIN;
                end
            end

            S_DNWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                wr_data    = rd_data;
                idx_next   = idx_inc;
                state_next = S_DNRD;
            end

            S_UPRD:
            begin
                if (idx_reg > pos_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_dec[AW-1:0];
                    state_next = S_UPWR;
                end
                else
                begin
                    // gap is open at the insert position
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[AW-1:0];
                    wr_data    = value_reg;
                    count_next = count_reg + CW'(1);
                    ok_next    = 1'b1;
                    state_next = S_FIN;
                end
            end

            S_UPWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                wr_data    = rd_data;
                idx_next   = idx_dec;
                state_next = S_UPRD;
            end

            S_FIN:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_ok_next    = ok_reg;
                    res_rem_next   = rem_reg;
                    res_count_next = count_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        kind_reg      <= kind_next;
        value_reg     <= value_next;
        pos_reg       <= pos_next;
        ok_reg        <= ok_next;
        rem_reg       <= rem_next;
        res_ok_reg    <= res_ok_next;
        res_rem_reg   <= res_rem_next;
        res_count_reg <= res_count_next;
    end

endmodule
